[hdl/lpf_pkg.sv]
// Package for the LED pattern fader: pattern tables, microcode words and the
// control store. Used by led_pattern_fader_unit; depends on nothing else.
package lpf_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned StepW  = 2;
  localparam int unsigned MsW    = 10;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned RemW   = DutyW + MsW;
  localparam int unsigned UpcW   = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned NumModes = 5;

  // pattern modes
  localparam logic [ModeW-1:0] MODE_OFF   = 3'd0;
  localparam logic [ModeW-1:0] MODE_ON    = 3'd1;
  localparam logic [ModeW-1:0] MODE_BLINK = 3'd2;
  localparam logic [ModeW-1:0] MODE_ALERT = 3'd3;
  localparam logic [ModeW-1:0] MODE_ERROR = 3'd4;

  // register indexes
  localparam logic REG_DUTY_DARK = 1'b0;
  localparam logic REG_DUTY_ON   = 1'b1;

  // item kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_LATCH   = 4'd1,
    OP_INC     = 4'd2,
    OP_DIVINIT = 4'd3,
    OP_DIVSTEP = 4'd4,
    OP_SETDUTY = 4'd5,
    OP_ADVANCE = 4'd6,
    OP_SELECT  = 4'd7,
    OP_EMIT    = 4'd8
  } uop_t;

  typedef enum logic [2:0] {
    CND_NEVER    = 3'd0,
    CND_ALWAYS   = 3'd1,
    CND_NO_INPUT = 3'd2,
    CND_SELECT   = 3'd3,
    CND_LEN_ZERO = 3'd4,
    CND_EXPIRED  = 3'd5,
    CND_CNT_NZ   = 3'd6,
    CND_OUT_BUSY = 3'd7
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [UpcW-1:0] target;
  } ucode_t;

  // control store addresses
  localparam logic [UpcW-1:0] UA_WAIT   = 4'd0;
  localparam logic [UpcW-1:0] UA_KIND   = 4'd1;
  localparam logic [UpcW-1:0] UA_LEN    = 4'd2;
  localparam logic [UpcW-1:0] UA_INC    = 4'd3;
  localparam logic [UpcW-1:0] UA_CHECK  = 4'd4;
  localparam logic [UpcW-1:0] UA_DIV    = 4'd5;
  localparam logic [UpcW-1:0] UA_SETD   = 4'd6;
  localparam logic [UpcW-1:0] UA_ADV    = 4'd7;
  localparam logic [UpcW-1:0] UA_SEL    = 4'd8;
  localparam logic [UpcW-1:0] UA_EMIT   = 4'd9;
  localparam logic [UpcW-1:0] UA_RET    = 4'd10;

  function automatic ucode_t ucode_rom(input logic [UpcW-1:0] a);
    ucode_t w;
    case (a)
      UA_WAIT:  w = '{OP_LATCH,   CND_NO_INPUT, UA_WAIT};
      UA_KIND:  w = '{OP_NOP,     CND_SELECT,   UA_SEL};
      UA_LEN:   w = '{OP_NOP,     CND_LEN_ZERO, UA_EMIT};
      UA_INC:   w = '{OP_INC,     CND_NEVER,    UA_WAIT};
      UA_CHECK: w = '{OP_DIVINIT, CND_EXPIRED,  UA_ADV};
      UA_DIV:   w = '{OP_DIVSTEP, CND_CNT_NZ,   UA_DIV};
      UA_SETD:  w = '{OP_SETDUTY, CND_ALWAYS,   UA_EMIT};
      UA_ADV:   w = '{OP_ADVANCE, CND_ALWAYS,   UA_EMIT};
      UA_SEL:   w = '{OP_SELECT,  CND_NEVER,    UA_WAIT};
      UA_EMIT:  w = '{OP_EMIT,    CND_OUT_BUSY, UA_EMIT};
      UA_RET:   w = '{OP_NOP,     CND_ALWAYS,   UA_WAIT};
      default:  w = '{OP_NOP,     CND_ALWAYS,   UA_WAIT};
    endcase
    return w;
  endfunction

  // index of the last step of a pattern
  function automatic logic [StepW-1:0] pat_last(input logic [ModeW-1:0] m);
    logic [StepW-1:0] r;
    case (m)
      MODE_BLINK:             r = 2'd1;
      MODE_ALERT, MODE_ERROR: r = 2'd3;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

  // 1 = lit, 0 = dark
  function automatic logic pat_level(input logic [ModeW-1:0] m,
                                     input logic [StepW-1:0] s);
    logic r;
    case (m)
      MODE_ON, MODE_BLINK:    r = (s == 2'd0);
      MODE_ALERT, MODE_ERROR: r = ~s[0];
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  // step length in ms, zero means the step never ends
  function automatic logic [MsW-1:0] pat_ms(input logic [ModeW-1:0] m,
                                            input logic [StepW-1:0] s);
    logic [MsW-1:0] r;
    case (m)
      MODE_BLINK: r = s[1] ? 10'd0 : 10'd250;
      MODE_ALERT: r = (s == 2'd0) ? 10'd1000 : 10'd100;
      MODE_ERROR: r = s[0] ? 10'd50 : 10'd100;
      default:    r = 10'd0;
    endcase
    return r;
  endfunction

  function automatic logic [StepW-1:0] prev_step(input logic [ModeW-1:0] m,
                                                 input logic [StepW-1:0] s);
    return (s == 2'd0) ? pat_last(m) : s - 2'd1;
  endfunction

endpackage

[hdl/led_pattern_fader_unit.sv]
// LED pattern fader top level: microcoded sequencer, fade datapath, APB
// registers. Depends on lpf_pkg.
//
// One item in, one result word out. A select item, a tick on an endless
// step and a tick that ends a step skip the divider; for a fading tick the
// duty is found by an 8-step restoring division of the weighted duty sum by
// the step length, one quotient bit per cycle. The result sits in an output
// register, so the next item is taken while it waits. Writing duty_dark or
// duty_on (byte addresses 0 and 4) also sets the duty to the level of the
// step before the current one; write only while the block is idle.
module led_pattern_fader_unit
  import lpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [ModeW-1:0] in_mode,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DutyW-1:0] out_duty,
  output logic [StepW-1:0] out_step_index,
  output logic             out_changed,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [UpcW-1:0]  upc_r, upc_nxt;
  logic             kind_r, kind_nxt;
  logic [ModeW-1:0] mode_in_r, mode_in_nxt;
  logic [ModeW-1:0] mode_r, mode_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [MsW-1:0]   elapsed_r, elapsed_nxt;
  logic [DutyW-1:0] duty_r, duty_nxt;
  logic [DutyW-1:0] duty_dark_r, duty_dark_nxt;
  logic [DutyW-1:0] duty_on_r, duty_on_nxt;
  logic             changed_r, changed_nxt;
  logic [RemW-1:0]  rem_r, rem_nxt;
  logic [DutyW-1:0] quo_r, quo_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DutyW-1:0] out_duty_r, out_duty_nxt;
  logic [StepW-1:0] out_step_r, out_step_nxt;
  logic             out_changed_r, out_changed_nxt;

  ucode_t           uw;
  logic             cond_hit;
  logic             out_busy;
  logic             cfg_wr;
  logic [MsW-1:0]   len;
  logic             lvl_prev, lvl_next;
  logic [MsW-1:0]   w_on, w_off;
  logic [RemW-1:0]  dsh;
  logic [RemW:0]    trial;
  logic [ModeW-1:0] sel_mode;

  assign uw       = ucode_rom(upc_r);
  assign in_ready = (upc_r == UA_WAIT);
  assign out_busy = out_valid_r & ~out_ready;
  assign cfg_wr   = psel & penable & pwrite;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_DUTY_ON) ? {24'd0, duty_on_r} : {24'd0, duty_dark_r};

  assign len      = pat_ms(mode_r, step_r);
  assign lvl_prev = pat_level(mode_r, prev_step(mode_r, step_r));
  assign lvl_next = pat_level(mode_r, step_r);
  assign sel_mode = (mode_in_r < ModeW'(NumModes)) ? mode_in_r : MODE_OFF;

  // weight of duty_on in the fade; duty_dark gets the rest of the step length
  always_comb begin
    case ({lvl_prev, lvl_next})
      2'b11:   w_on = len;
      2'b10:   w_on = len - elapsed_r;
      2'b01:   w_on = elapsed_r;
      default: w_on = '0;
    endcase
    w_off = len - w_on;
  end

  assign dsh   = RemW'(len) << cnt_r;
  assign trial = {1'b0, rem_r} - {1'b0, dsh};

  always_comb begin
    case (uw.cond)
      CND_NEVER:    cond_hit = 1'b0;
      CND_ALWAYS:   cond_hit = 1'b1;
      CND_NO_INPUT: cond_hit = ~in_valid;
      CND_SELECT:   cond_hit = (kind_r == KIND_SELECT);
      CND_LEN_ZERO: cond_hit = (len == '0);
      CND_EXPIRED:  cond_hit = (elapsed_r >= len);
      CND_CNT_NZ:   cond_hit = (cnt_r != '0);
      CND_OUT_BUSY: cond_hit = out_busy;
      default:      cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt         = cond_hit ? uw.target : upc_r + 4'd1;
    kind_nxt        = kind_r;
    mode_in_nxt     = mode_in_r;
    mode_nxt        = mode_r;
    step_nxt        = step_r;
    elapsed_nxt     = elapsed_r;
    duty_nxt        = duty_r;
    duty_dark_nxt   = duty_dark_r;
    duty_on_nxt     = duty_on_r;
    changed_nxt     = changed_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_duty_nxt    = out_duty_r;
    out_step_nxt    = out_step_r;
    out_changed_nxt = out_changed_r;

    case (uw.op)
      OP_LATCH: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          mode_in_nxt = in_mode;
          changed_nxt = 1'b0;
        end
      end
      OP_INC: begin
        elapsed_nxt = elapsed_r + 10'd1;
      end
      OP_DIVINIT: begin
        rem_nxt = RemW'(duty_dark_r) * RemW'(w_off) + RemW'(duty_on_r) * RemW'(w_on);
        quo_nxt = '0;
        cnt_nxt = '1;
      end
      OP_DIVSTEP: begin
        if (!trial[RemW]) begin
          rem_nxt        = trial[RemW-1:0];
          quo_nxt[cnt_r] = 1'b1;
        end
        cnt_nxt = cnt_r - 3'd1;
      end
      OP_SETDUTY: begin
        duty_nxt    = quo_r;
        changed_nxt = 1'b1;
      end
      OP_ADVANCE: begin
        elapsed_nxt = '0;
        step_nxt    = (step_r == pat_last(mode_r)) ? 2'd0 : step_r + 2'd1;
      end
      OP_SELECT: begin
        mode_nxt    = sel_mode;
        step_nxt    = '0;
        elapsed_nxt = '0;
        duty_nxt    = pat_level(sel_mode, pat_last(sel_mode)) ? duty_on_r : duty_dark_r;
        changed_nxt = 1'b1;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt   = 1'b1;
          out_duty_nxt    = duty_r;
          out_step_nxt    = step_r;
          out_changed_nxt = changed_r;
        end
      end
      default: begin
      end
    endcase

    // register write: duty jumps to the level of the previous step
    if (cfg_wr) begin
      if (paddr[2] == REG_DUTY_ON) begin
        duty_on_nxt = pwdata[DutyW-1:0];
      end else begin
        duty_dark_nxt = pwdata[DutyW-1:0];
      end
      duty_nxt = lvl_prev ? duty_on_nxt : duty_dark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UA_WAIT;
      kind_r      <= KIND_TICK;
      mode_r      <= MODE_OFF;
      step_r      <= '0;
      elapsed_r   <= '0;
      duty_r      <= 8'd255;
      duty_dark_r <= 8'd255;
      duty_on_r   <= 8'd0;
      changed_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      kind_r      <= kind_nxt;
      mode_r      <= mode_nxt;
      step_r      <= step_nxt;
      elapsed_r   <= elapsed_nxt;
      duty_r      <= duty_nxt;
      duty_dark_r <= duty_dark_nxt;
      duty_on_r   <= duty_on_nxt;
      changed_r   <= changed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_in_r     <= mode_in_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    out_duty_r    <= out_duty_nxt;
    out_step_r    <= out_step_nxt;
    out_changed_r <= out_changed_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_duty       = out_duty_r;
  assign out_step_index = out_step_r;
  assign out_changed    = out_changed_r;

endmodule

[tb/sv/led_pattern_fader_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for led_pattern_fader_unit: a directed table, then random pattern runs and
// register changes; each result word is checked against its typed table value or an
// in-bench fade predictor. Depends on lpf_pkg and led_pattern_fader_unit.
module led_pattern_fader_unit_tb;
  import lpf_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [StepW-1:0] step;
    logic             changed;
  } led_word_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_act_t;

  typedef struct packed {
    row_act_t         act;
    logic             reg_idx;
    logic [7:0]       value;
    logic             kind;
    logic [ModeW-1:0] mode;
    logic             typed;
    led_word_t        want;
  } dir_row_t;

  localparam int DIR_ROWS = 30;
  // typed rows: values read straight off the pattern levels and duty registers
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_OFF, 1'b1, '{8'd255, 2'd0, 1'b0}},
    // modes 5..7 fall back to off
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, 3'd7, 1'b1, '{8'd255, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_ON, 1'b1, '{8'd0, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_ERROR, 1'b1, '{8'd0, 2'd0, 1'b0}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_BLINK, 1'b1, '{8'd255, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, 3'd7, 1'b0, '0},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_ALERT, 1'b1, '{8'd255, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_ON, 1'b0, '0},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_ERROR, 1'b1, '{8'd255, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_BLINK, 1'b0, '0},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, 3'd5, 1'b1, '{8'd255, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, 3'd6, 1'b1, '{8'd255, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_OFF, 1'b1, '{8'd255, 2'd0, 1'b1}},
    // reversed polarity: lit above dark
    '{ROW_REG, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_REG, REG_DUTY_ON, 8'd255, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_ON, 1'b1, '{8'd255, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_BLINK, 1'b1, '{8'd0, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_REG, REG_DUTY_DARK, 8'd255, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_REG, REG_DUTY_ON, 8'd255, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_ERROR, 1'b1, '{8'd255, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_REG, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_REG, REG_DUTY_ON, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_SELECT, MODE_ALERT, 1'b1, '{8'd0, 2'd0, 1'b1}},
    '{ROW_ITEM, REG_DUTY_DARK, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_REG, REG_DUTY_DARK, 8'd255, KIND_TICK, MODE_OFF, 1'b0, '0},
    '{ROW_REG, REG_DUTY_ON, 8'd0, KIND_TICK, MODE_OFF, 1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_kind;
  logic [ModeW-1:0] in_mode;
  logic             out_valid;
  logic             out_ready;
  logic [DutyW-1:0] out_duty;
  logic [StepW-1:0] out_step_index;
  logic             out_changed;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  led_pattern_fader_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty       (out_duty),
    .out_step_index (out_step_index),
    .out_changed    (out_changed),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // fader state as the predictor sees it
  logic [7:0]       fd_off;
  logic [7:0]       fd_on;
  logic [ModeW-1:0] fd_mode;
  logic [StepW-1:0] fd_step;
  int               fd_elapsed;
  logic [7:0]       fd_duty;

  led_word_t duty_expect_q[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        src_left;
  bit        src_calm;

  function automatic int steps_in(input logic [ModeW-1:0] m);
    case (m)
      MODE_BLINK:             return 2;
      MODE_ALERT, MODE_ERROR: return 4;
      default:                return 1;
    endcase
  endfunction

  function automatic int lit_at(input logic [ModeW-1:0] m, input logic [StepW-1:0] s);
    case (m)
      MODE_ON:                return 1;
      MODE_BLINK:             return (s == 0) ? 1 : 0;
      MODE_ALERT, MODE_ERROR: return (s[0] == 1'b0) ? 1 : 0;
      default:                return 0;
    endcase
  endfunction

  // 0 = step never ends
  function automatic int step_ms(input logic [ModeW-1:0] m, input logic [StepW-1:0] s);
    case (m)
      MODE_BLINK: return 250;
      MODE_ALERT: return (s == 0) ? 1000 : 100;
      MODE_ERROR: return s[0] ? 50 : 100;
      default:    return 0;
    endcase
  endfunction

  // duty at e/d of the way from the previous step's level to this step's level
  function automatic logic [7:0] faded_duty(input int e, input int d);
    int prior_lvl, cur_lvl, num, span, scaled;
    logic [StepW-1:0] prior_step;
    prior_step = (fd_step == 0) ? StepW'(steps_in(fd_mode) - 1) : fd_step - 2'd1;
    prior_lvl  = lit_at(fd_mode, prior_step);
    cur_lvl    = lit_at(fd_mode, fd_step);
    num        = prior_lvl * d + (cur_lvl - prior_lvl) * e;
    span       = int'(fd_off) - int'(fd_on);
    scaled     = int'(fd_off) * d - span * num;
    return 8'(scaled / d);
  endfunction

  function automatic led_word_t next_led_word(input logic kind, input logic [ModeW-1:0] mode);
    led_word_t w;
    int len;
    w.changed = 1'b0;
    if (kind == KIND_SELECT) begin
      fd_mode    = (mode <= MODE_ERROR) ? mode : MODE_OFF;
      fd_step    = '0;
      fd_elapsed = 0;
      fd_duty    = faded_duty(0, 1);
      w.changed  = 1'b1;
    end else begin
      len = step_ms(fd_mode, fd_step);
      if (len != 0) begin
        fd_elapsed++;
        if (fd_elapsed >= len) begin
          fd_elapsed = 0;
          fd_step = (int'(fd_step) + 1 >= steps_in(fd_mode)) ? '0 : fd_step + 2'd1;
        end else begin
          fd_duty   = faded_duty(fd_elapsed, len);
          w.changed = 1'b1;
        end
      end
    end
    w.duty = fd_duty;
    w.step = fd_step;
    return w;
  endfunction

  // runs with random idle gaps are mixed at random with calm runs (one in four) that have no gaps at all
  function automatic int idle_cycles(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0d] mismatch on %s: got %0d, want %0d", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic kind, input logic [ModeW-1:0] mode,
                           input logic typed, input led_word_t typed_word);
    int gap;
    led_word_t w;
    gap = idle_cycles(src_left, src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_mode  <= mode;
    do @(posedge clk); while (!in_ready);
    w = next_led_word(kind, mode);
    duty_expect_q.push_back(typed ? typed_word : w);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DUTY_DARK) fd_off = val;
    else fd_on = val;
    fd_duty = faded_duty(0, 1);
    // the bus is left idle before the next transfer
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    led_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (duty_expect_q.size() == 0) begin
        report_mismatch("unexpected word, duty", out_duty, -1);
      end else begin
        want = duty_expect_q.pop_front();
        if (out_duty != want.duty) report_mismatch("duty", out_duty, want.duty);
        if (out_step_index != want.step) report_mismatch("step_index", out_step_index, want.step);
        if (out_changed != want.changed) report_mismatch("changed", out_changed, want.changed);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : sink_side
    int gap;
    int left;
    bit calm;
    left = 0;
    calm = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = idle_cycles(left, calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int sent, ticks, split, r;
    logic [ModeW-1:0] mode;
    bit first_run;
    src_left   = 0;
    src_calm   = 1'b0;
    fd_off     = 8'd255;
    fd_on      = 8'd0;
    fd_mode    = MODE_OFF;
    fd_step    = '0;
    fd_elapsed = 0;
    fd_duty    = 8'd255;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_kind  <= KIND_TICK;
    in_mode  <= MODE_OFF;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].act == ROW_REG) begin
        drain();
        reg_write(DIR_TABLE[i].reg_idx, DIR_TABLE[i].value);
      end else begin
        send_word(DIR_TABLE[i].kind, DIR_TABLE[i].mode, DIR_TABLE[i].typed, DIR_TABLE[i].want);
      end
    end

    // random pattern runs: a select, then a train of ticks; the first run walks a
    // whole alert cycle, later ones are cut short at random by the next select
    sent = 0;
    first_run = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (first_run) mode = MODE_ALERT;
      else if (r <= 2) mode = MODE_ERROR;
      else if (r <= 5) mode = MODE_BLINK;
      else if (r == 6) mode = MODE_ALERT;
      else if (r == 7) mode = MODE_ON;
      else if (r == 8) mode = MODE_OFF;
      else mode = ModeW'($urandom_range(5, 7));
      case (mode)
        MODE_ALERT: ticks = first_run ? $urandom_range(1300, 1340) : $urandom_range(1, 150);
        MODE_ERROR: ticks = $urandom_range(1, 350);
        MODE_BLINK: ticks = $urandom_range(1, 550);
        default:    ticks = $urandom_range(0, 8);
      endcase
      // the last run stops at the item budget
      if (ticks > RANDOM_ITEMS - sent - 1) ticks = RANDOM_ITEMS - sent - 1;
      first_run = 1'b0;
      // duty registers change mid-run in some runs
      split = ($urandom_range(0, 9) < 4) ? $urandom_range(0, ticks) : -1;
      send_word(KIND_SELECT, mode, 1'b0, '0);
      sent++;
      for (int t = 0; t <= ticks; t++) begin
        if (t == split) begin
          drain();
          r = $urandom_range(0, 3);
          reg_write(1'($urandom_range(0, 1)),
                    (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255)));
        end
        if (t < ticks) begin
          send_word(KIND_TICK, ModeW'($urandom_range(0, 7)), 1'b0, '0);
          sent++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lpf_pkg.sv
hdl/led_pattern_fader_unit.sv
tb/sv/led_pattern_fader_unit_tb.sv
